[rtl/core/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue: opcodes, status
// codes, request and response payloads, memory command.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

  // Default geometry
  localparam int unsigned DEPTH_DEF       = 16;
  localparam int unsigned ENTRY_WIDTH_DEF = 32;

  // Payload field widths
  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  // Operation codes; the remaining codes act as a query
  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_POP_FRONT  = 3'd1,
    OP_PUSH_FRONT = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_QUERY      = 3'd4
  } deq_op_e;

  // Completion status
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } deq_status_e;

  // Request payload
  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [VALUE_W-1:0]  entry_value;
  } deq_req_t;

  // Response payload
  typedef struct packed {
    logic [VALUE_W-1:0]  popped_value;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  entry_count;
    logic                is_empty;
  } deq_rsp_t;

  // Ring memory command
  typedef struct packed {
    logic wr;
    logic rd;
  } deq_mem_cmd_t;

endpackage

`default_nettype wire

[rtl/core/deq_ring_mem.sv]
// ----------------------------------------------------------------------------
// deq_ring_mem
// Single-port synchronous ring store with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ring_mem
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH       = DEPTH_DEF,
  parameter int unsigned ENTRY_WIDTH = ENTRY_WIDTH_DEF,
  localparam int unsigned PTR_W      = $clog2(DEPTH)
) (
  input  wire logic                   clk_i,
  input  wire deq_mem_cmd_t           cmd_i,
  input  wire logic [PTR_W-1:0]       addr_i,
  input  wire logic [ENTRY_WIDTH-1:0] wdata_i,
  output logic      [ENTRY_WIDTH-1:0] rdata_o
);

  logic [ENTRY_WIDTH-1:0] mem_q [DEPTH];
  logic [ENTRY_WIDTH-1:0] rdata_q;

  // Write on request; capture read data, hold it until the next read
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/deq_ctrl.sv]
// ----------------------------------------------------------------------------
// deq_ctrl
// Ring pointer control: decodes the request, issues the memory access,
// updates front index and count, and registers the response.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ctrl
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH       = DEPTH_DEF,
  parameter int unsigned ENTRY_WIDTH = ENTRY_WIDTH_DEF,
  localparam int unsigned PTR_W      = $clog2(DEPTH),
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1),
  localparam int unsigned SUM_W      = CNT_W + 1
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire deq_req_t               in_req_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output deq_rsp_t                    out_rsp_o,
  output deq_mem_cmd_t                mem_cmd_o,
  output logic      [PTR_W-1:0]       mem_addr_o,
  output logic      [ENTRY_WIDTH-1:0] mem_wdata_o,
  input  wire logic [ENTRY_WIDTH-1:0] mem_rdata_i
);

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_e;

  state_e                state_q;
  logic [PTR_W-1:0]      front_q, front_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic                  pop_ok_q, pop_ok_d;
  logic                  out_valid_q;
  deq_rsp_t              out_rsp_q;

  logic                  accept;
  logic                  load_out;
  logic                  is_full;
  logic                  is_empty;
  logic [PTR_W-1:0]      slot_back;
  logic [PTR_W-1:0]      slot_last;
  logic [PTR_W-1:0]      front_inc;
  logic [PTR_W-1:0]      front_dec;

  // Fold a sum of two ring offsets back into the ring
  function automatic logic [PTR_W-1:0] wrap_slot(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] t;
    t = s - SUM_W'(DEPTH);
    if (s >= SUM_W'(DEPTH)) begin
      return PTR_W'(t);
    end
    return PTR_W'(s);
  endfunction

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign is_full  = (count_q == CNT_W'(DEPTH));
  assign is_empty = (count_q == '0);

  // Ring slot arithmetic
  always_comb begin
    slot_back = wrap_slot(SUM_W'(front_q) + SUM_W'(count_q));
    slot_last = wrap_slot(SUM_W'(front_q) + SUM_W'(count_q) - SUM_W'(1));
    front_inc = (front_q == PTR_W'(DEPTH - 1)) ? '0 : front_q + PTR_W'(1);
    front_dec = (front_q == '0) ? PTR_W'(DEPTH - 1) : front_q - PTR_W'(1);
  end

  // Decode the request into a memory access and the pointer update
  always_comb begin
    mem_cmd_o   = '0;
    mem_addr_o  = front_q;
    mem_wdata_o = ENTRY_WIDTH'(in_req_i.entry_value);
    front_d     = front_q;
    count_d     = count_q;
    status_d    = ST_DONE;
    pop_ok_d    = 1'b0;
    if (accept) begin
      unique case (in_req_i.opcode)
        OP_PUSH_BACK: begin
          if (is_full) begin
            status_d = ST_FULL;
          end else begin
            mem_cmd_o.wr = 1'b1;
            mem_addr_o   = slot_back;
            count_d      = count_q + CNT_W'(1);
          end
        end
        OP_PUSH_FRONT: begin
          if (is_full) begin
            status_d = ST_FULL;
          end else begin
            mem_cmd_o.wr = 1'b1;
            mem_addr_o   = front_dec;
            front_d      = front_dec;
            count_d      = count_q + CNT_W'(1);
          end
        end
        OP_POP_FRONT: begin
          if (is_empty) begin
            status_d = ST_EMPTY;
          end else begin
            mem_cmd_o.rd = 1'b1;
            mem_addr_o   = front_q;
            front_d      = front_inc;
            count_d      = count_q - CNT_W'(1);
            pop_ok_d     = 1'b1;
          end
        end
        OP_POP_BACK: begin
          if (is_empty) begin
            status_d = ST_EMPTY;
          end else begin
            mem_cmd_o.rd = 1'b1;
            mem_addr_o   = slot_last;
            count_d      = count_q - CNT_W'(1);
            pop_ok_d     = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Response can load when the output register is free or being drained
  assign load_out = (state_q == S_RESP) && (!out_valid_q || !out_stall_i);

  // State, pointers, pending request info and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      status_q    <= ST_DONE;
      pop_ok_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_rsp_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            front_q  <= front_d;
            count_q  <= count_d;
            status_q <= status_d;
            pop_ok_q <= pop_ok_d;
            state_q  <= S_RESP;
          end
        end
        S_RESP: begin
          if (load_out) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      if (load_out) begin
        out_valid_q            <= 1'b1;
        out_rsp_q.popped_value <= pop_ok_q ? VALUE_W'(mem_rdata_i) : '0;
        out_rsp_q.status       <= status_q;
        out_rsp_q.entry_count  <= COUNT_W'(count_q);
        out_rsp_q.is_empty     <= (count_q == '0);
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

`default_nettype wire

[rtl/core/double_ended_queue.sv]
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of entry handles held in a ring memory.
//
//   Channel  Direction  Payload    Handshake
//   in       input      deq_req_t  in_valid_i / in_stall_o
//   out      output     deq_rsp_t  out_valid_o / out_stall_i
//
// Each request passes through S_IDLE, where the accept edge issues the ring
// memory access and updates the pointers, and S_RESP, which loads the
// response once the registered memory read has returned.
// A new request is taken while an earlier response still waits in the
// output register; a stalled output holds the second request in place.
// Reset clears front index, count and handshake state; the ring memory
// itself is not cleared, and pops only ever read written slots.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH       = DEPTH_DEF,
  parameter int unsigned ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire deq_req_t in_req_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output deq_rsp_t      out_rsp_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);

  deq_mem_cmd_t           mem_cmd;
  logic [PTR_W-1:0]       mem_addr;
  logic [ENTRY_WIDTH-1:0] mem_wdata;
  logic [ENTRY_WIDTH-1:0] mem_rdata;

  // Pointer control and response register
  deq_ctrl #(
    .DEPTH       (DEPTH),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .mem_cmd_o   (mem_cmd),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  // Entry storage
  deq_ring_mem #(
    .DEPTH       (DEPTH),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .cmd_i   (mem_cmd),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire

[rtl/core/deq_checker.sv]
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks on the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_checker
  import deq_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_stall_o,
  input wire logic     out_valid_o,
  input wire logic     out_stall_i,
  input wire deq_rsp_t out_rsp_o
);

  // Stalled response holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled response changed");

  // An accepted request occupies the block for the following cycle
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted in back-to-back cycles");

  // Empty flag agrees with the count
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.is_empty |-> out_rsp_o.entry_count == '0)
    else $error("empty flag with nonzero count");

  // Only known status codes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.status == ST_DONE || out_rsp_o.status == ST_EMPTY ||
                    out_rsp_o.status == ST_FULL)
    else $error("unknown status code");

  // A failed operation returns no value
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status != ST_DONE |-> out_rsp_o.popped_value == '0)
    else $error("value returned on failed operation");

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);

`default_nettype wire

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the double-ended queue. Requests are driven
// through the valid/stall input channel with random gaps. Responses are
// taken with random back-pressure. Each response is checked field by
// field against a behavioral ring-buffer predictor that runs at request
// accept time. Directed tests cover the empty queue, both ends and pointer
// wrap. Random bursts then fill, drain, overflow and mix the queue.
// ----------------------------------------------------------------------------
module tb_top;
  import deq_pkg::*;

  localparam int unsigned RING_DEPTH   = DEPTH_DEF;
  localparam int unsigned SLOT_W       = $clog2(RING_DEPTH);
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned RANDOM_ITEMS = 1330;

  // Opcodes outside the defined set behave as a query
  localparam logic [OPCODE_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  deq_req_t in_req    = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  deq_rsp_t out_rsp;

  // Predictor state: ring contents, front slot and fill level
  logic [VALUE_W-1:0] ring_copy [RING_DEPTH];
  logic [SLOT_W-1:0]  head_slot  = '0;
  logic [COUNT_W-1:0] fill_level = '0;

  deq_rsp_t    rsp_expect_q[$];
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  bit          calm        = 1'b0;

  double_ended_queue dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_rsp_o  (out_rsp)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Apply one request to the predicted queue and return its response
  function automatic deq_rsp_t deque_model_step(deq_req_t req);
    deq_rsp_t          rsp;
    logic [SLOT_W-1:0] slot;
    rsp = '0;
    rsp.status = ST_DONE;
    case (req.opcode)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (fill_level == COUNT_W'(RING_DEPTH)) begin
          rsp.status = ST_FULL;
        end else if (req.opcode == OP_PUSH_BACK) begin
          slot = head_slot + SLOT_W'(fill_level);
          ring_copy[slot] = req.entry_value;
          fill_level = fill_level + 1'b1;
        end else begin
          head_slot = head_slot - 1'b1;
          ring_copy[head_slot] = req.entry_value;
          fill_level = fill_level + 1'b1;
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (fill_level == '0) begin
          rsp.status = ST_EMPTY;
        end else if (req.opcode == OP_POP_FRONT) begin
          rsp.popped_value = ring_copy[head_slot];
          head_slot = head_slot + 1'b1;
          fill_level = fill_level - 1'b1;
        end else begin
          slot = head_slot + SLOT_W'(fill_level - 1'b1);
          rsp.popped_value = ring_copy[slot];
          fill_level = fill_level - 1'b1;
        end
      end
      default: ;
    endcase
    rsp.entry_count = fill_level;
    rsp.is_empty    = (fill_level == '0);
    return rsp;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch on %s: got 0x%0h, expected 0x%0h", what, got, want);
    error_count++;
  endtask

  // Idle at random, then hold the request until it is taken
  task automatic issue_request(deq_req_t req);
    while (!calm && $urandom_range(0, 99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk_i); while (in_stall);
    rsp_expect_q.push_back(deque_model_step(req));
  endtask

  // Shorthand for building a request
  function automatic deq_req_t make_req(logic [OPCODE_W-1:0] op, logic [VALUE_W-1:0] val);
    deq_req_t req;
    req.opcode      = op;
    req.entry_value = val;
    return req;
  endfunction

  // Pops on empty, query and the spare opcodes before anything is held
  task automatic test_empty_queue();
    issue_request(make_req(OP_QUERY, 32'hFFFF_FFFF));
    issue_request(make_req(OP_POP_FRONT, 32'h1234_5678));
    issue_request(make_req(OP_POP_BACK, '0));
    issue_request(make_req(OP_SPARE_5, 32'hDEAD_BEEF));
    issue_request(make_req(OP_SPARE_6, '1));
    issue_request(make_req(OP_SPARE_7, '0));
  endtask

  // Push and pop at both ends with extreme values
  task automatic test_both_ends();
    issue_request(make_req(OP_PUSH_BACK, '0));
    issue_request(make_req(OP_PUSH_FRONT, '1));
    issue_request(make_req(OP_PUSH_BACK, 32'hA5A5_A5A5));
    issue_request(make_req(OP_QUERY, '0));
    issue_request(make_req(OP_POP_FRONT, '0));
    issue_request(make_req(OP_POP_BACK, '1));
    issue_request(make_req(OP_POP_BACK, '0));
    issue_request(make_req(OP_POP_FRONT, '0));
  endtask

  // Walk the front pointer backward across slot zero
  task automatic test_wraparound();
    issue_request(make_req(OP_PUSH_FRONT, 32'h5A5A_5A5A));
    issue_request(make_req(OP_PUSH_FRONT, 32'h0000_0001));
    issue_request(make_req(OP_POP_BACK, '0));
    issue_request(make_req(OP_POP_BACK, '0));
  endtask

  // Bursts biased to fill, drain, mix or query; one stretch runs without idling
  task automatic test_random_sequences();
    int unsigned sent;
    int unsigned burst;
    int unsigned mode;
    bit          favor;
    deq_req_t    req;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mode  = $urandom_range(0, 9);
      burst = $urandom_range(8, 40);
      calm  = (sent >= 500 && sent < 700);
      for (int unsigned i = 0; i < burst; i++) begin
        case ($urandom_range(0, 15))
          0:       req.entry_value = '0;
          1:       req.entry_value = '1;
          default: req.entry_value = $urandom();
        endcase
        favor = ($urandom_range(0, 99) < 85);
        if (mode < 4) begin
          if (favor) req.opcode = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
          else       req.opcode = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
        end else if (mode < 8) begin
          if (favor) req.opcode = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
          else       req.opcode = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        end else if (mode == 8) begin
          req.opcode = OPCODE_W'($urandom_range(OP_PUSH_BACK, OP_SPARE_7));
        end else begin
          req.opcode = OPCODE_W'($urandom_range(OP_QUERY, OP_SPARE_7));
        end
        issue_request(req);
        sent++;
      end
    end
    calm = 1'b0;
  endtask

  // Random back-pressure on the response side
  always @(posedge clk_i) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 35);
  end

  // Compare each taken response with the oldest prediction
  always @(posedge clk_i) begin : check_responses
    deq_rsp_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (rsp_expect_q.size() == 0) begin
        report_mismatch("response with nothing pending", out_rsp, '0);
      end else begin
        want = rsp_expect_q.pop_front();
        if (out_rsp.popped_value !== want.popped_value)
          report_mismatch("popped_value", out_rsp.popped_value, want.popped_value);
        if (out_rsp.status !== want.status)
          report_mismatch("status", out_rsp.status, want.status);
        if (out_rsp.entry_count !== want.entry_count)
          report_mismatch("entry_count", out_rsp.entry_count, want.entry_count);
        if (out_rsp.is_empty !== want.is_empty)
          report_mismatch("is_empty", out_rsp.is_empty, want.is_empty);
      end
    end
  end

  // End the run when nothing moves on either channel for too long
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_queue();
    test_both_ends();
    test_wraparound();
    test_random_sequences();
    in_valid <= 1'b0;
    // Drain outstanding responses, then allow the pipeline to settle
    while (rsp_expect_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
